// ===== src/bgpl_pkg.sv =====
package bgpl_pkg;

  localparam int MEM_BYTES = 8192;
  localparam int ADDR_W    = $clog2(MEM_BYTES);

  localparam int IDX_W     = 20;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 10;

  localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_CODE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LAST_CODE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_TOTAL  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_BYTES  = 3'd5;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  localparam logic [8:0] FALLBACK_CODE = 9'd63;

endpackage

// ===== src/bitmap_glyph_pixel_lookup_core.sv =====
// Channel  | Ports                                           | Direction
// ---------+-------------------------------------------------+----------
// request  | start_i, busy_o, req_type_i, mem_addr_i,        | in
//          | mem_data_i, char_code_i, pixel_x_i, pixel_y_i   |
// result   | done_o, pixel_on_o                              | out
// config   | cfg_we_i, cfg_idx_i, cfg_wdata_i                | in
//
// One request beat is taken every cycle; busy_o is never raised.
// A query answers on done_o after its beat passes the input register, the
// multiply register, and the result register, which takes the index add and
// the glyph memory read. Writes produce no beat and pass the same stages, so
// memory writes and reads keep their order. Reset clears the pipeline and the
// registers, not the memory. The receiver cannot stall.
module bitmap_glyph_pixel_lookup_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic                          req_type_i,
  input  logic [12:0]                   mem_addr_i,
  input  logic [7:0]                    mem_data_i,
  input  logic [7:0]                    char_code_i,
  input  logic signed [7:0]             pixel_x_i,
  input  logic signed [7:0]             pixel_y_i,
  output logic                          done_o,
  output logic                          pixel_on_o,
  input  logic                          cfg_we_i,
  input  logic [bgpl_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [bgpl_pkg::CFG_DAT_W-1:0] cfg_wdata_i
);
  import bgpl_pkg::*;

  localparam logic [IDX_W-1:0] MEM_LIM = IDX_W'(MEM_BYTES);

  logic [6:0] glyph_width_q, glyph_height_q;
  logic [8:0] first_code_q, last_code_q;
  logic [9:0] glyph_total_q, glyph_bytes_q;
  logic [IDX_W-1:0] lim_q;

  logic        s1_vld_q, s1_type_q;
  logic [12:0] s1_addr_q;
  logic [7:0]  s1_data_q, s1_code_q;
  logic [7:0]  s1_x_q, s1_y_q;

  logic        s2_vld_q, s2_type_q, s2_ok_q;
  logic [12:0] s2_addr_q;
  logic [7:0]  s2_data_q;
  logic [18:0] s2_prod_q;
  logic [11:0] s2_row_q;
  logic [3:0]  s2_col_q;
  logic [2:0]  s2_bit_q;

  logic        s3_vld_q, s3_hit_q;
  logic [2:0]  s3_bit_q;
  logic [7:0]  rdata_q;

  logic [7:0] mem_q [MEM_BYTES];

  logic [8:0]       code_ext, glyph, gofs;
  logic             code_in, fb_in;
  logic [7:0]       stride_sum;
  logic [4:0]       stride;
  logic             x_ok, y_ok;
  logic [IDX_W-1:0] idx, waddr;
  logic             hit;

  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      glyph_width_q  <= '0;
      glyph_height_q <= '0;
      first_code_q   <= '0;
      last_code_q    <= '0;
      glyph_total_q  <= '0;
      glyph_bytes_q  <= '0;
      lim_q          <= '0;
    end else begin
      lim_q <= IDX_W'(glyph_total_q) * IDX_W'(glyph_bytes_q);
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_GLYPH_WIDTH:  glyph_width_q  <= cfg_wdata_i[6:0];
          CFG_GLYPH_HEIGHT: glyph_height_q <= cfg_wdata_i[6:0];
          CFG_FIRST_CODE:   first_code_q   <= cfg_wdata_i[8:0];
          CFG_LAST_CODE:    last_code_q    <= cfg_wdata_i[8:0];
          CFG_GLYPH_TOTAL:  glyph_total_q  <= cfg_wdata_i;
          CFG_GLYPH_BYTES:  glyph_bytes_q  <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= start_i && !busy_o;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q && (s2_type_q == REQ_QUERY);
    end
  end

  always_ff @(posedge clk_i) begin
    s1_type_q <= req_type_i;
    s1_addr_q <= mem_addr_i;
    s1_data_q <= mem_data_i;
    s1_code_q <= char_code_i;
    s1_x_q    <= pixel_x_i;
    s1_y_q    <= pixel_y_i;
  end

  // Out-of-range codes fall back to '?', then to the first code.
  always_comb begin
    code_ext   = {1'b0, s1_code_q};
    code_in    = (code_ext >= first_code_q) && (code_ext <= last_code_q);
    fb_in      = (FALLBACK_CODE >= first_code_q) && (FALLBACK_CODE <= last_code_q);
    glyph      = code_in ? code_ext : (fb_in ? FALLBACK_CODE : first_code_q);
    gofs       = glyph - first_code_q;
    stride_sum = {1'b0, glyph_width_q} + 8'd7;
    stride     = stride_sum[7:3];
    x_ok       = !s1_x_q[7] && (s1_x_q[6:0] < glyph_width_q);
    y_ok       = !s1_y_q[7] && (s1_y_q[6:0] < glyph_height_q);
  end

  always_ff @(posedge clk_i) begin
    s2_type_q <= s1_type_q;
    s2_addr_q <= s1_addr_q;
    s2_data_q <= s1_data_q;
    s2_ok_q   <= x_ok && y_ok;
    s2_prod_q <= 19'(gofs) * 19'(glyph_bytes_q);
    s2_row_q  <= 12'(s1_y_q[6:0]) * 12'(stride);
    s2_col_q  <= s1_x_q[6:3];
    s2_bit_q  <= s1_x_q[2:0];
  end

  always_comb begin
    idx   = IDX_W'(s2_prod_q) + IDX_W'(s2_row_q) + IDX_W'(s2_col_q);
    hit   = s2_ok_q && (idx < lim_q) && (idx < MEM_LIM);
    waddr = IDX_W'(s2_addr_q);
  end

  always_ff @(posedge clk_i) begin
    if (s2_vld_q && (s2_type_q == REQ_WRITE)) begin
      if (waddr < MEM_LIM) begin
        mem_q[waddr[ADDR_W-1:0]] <= s2_data_q;
      end
    end else begin
      rdata_q <= mem_q[idx[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    s3_hit_q <= hit;
    s3_bit_q <= s2_bit_q;
  end

  assign done_o     = s3_vld_q;
  assign pixel_on_o = s3_vld_q && s3_hit_q && rdata_q[3'd7 - s3_bit_q];

endmodule

// ===== src/bgpl_checker.sv =====
module bgpl_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          start_i,
  input logic                          busy_o,
  input logic                          req_type_i,
  input logic signed [7:0]             pixel_x_i,
  input logic                          done_o,
  input logic                          pixel_on_o
);
  import bgpl_pkg::*;

  logic query_beat;

  assign query_beat = start_i && !busy_o && (req_type_i == REQ_QUERY);

  // Every query beat is answered on done_o.
  a_query_answered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    query_beat |-> ##3 done_o)
    else $error("query beat not answered after three cycles");

  // No result beat appears without a matching earlier query.
  a_no_spurious_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(query_beat, 3))
    else $error("result beat without a matching query");

  // A negative column lies outside every glyph.
  a_negative_x_dark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (query_beat && pixel_x_i[7]) |-> ##3 !pixel_on_o)
    else $error("pixel lit for a negative column");

  a_pixel_needs_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !done_o |-> !pixel_on_o)
    else $error("pixel_on_o high outside a result beat");

endmodule

bind bitmap_glyph_pixel_lookup_core bgpl_checker u_bgpl_checker (.*);
